// ----- hw/rtl/crhm_pkg.sv -----
// Shared constants, codes and structures of the control read matcher.
package crhm_pkg;

  localparam int NUM_CONTROLS = 16;
  localparam int CONTROL_LEN  = 64;

  // Widths of the channel fields and configuration port.
  localparam int CMD_W     = 2;
  localparam int CIDX_W    = 4;
  localparam int FPOS_W    = 6;
  localparam int BASE_W    = 2;
  localparam int LENV_W    = 7;
  localparam int CNT_W     = 7;
  localparam int NUM_W     = 32;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int SLEN_W    = 7;
  localparam int MERR_W    = 7;
  localparam int CUSE_W    = 5;

  // Derived internal widths.
  localparam int IDX_W  = (NUM_CONTROLS > 1) ? $clog2(NUM_CONTROLS) : 1;
  localparam int USED_W = $clog2(NUM_CONTROLS + 1);
  localparam int POS_W  = $clog2(CONTROL_LEN);
  localparam int LEN_W  = $clog2(CONTROL_LEN + 1);
  localparam int RP_W   = 7;
  localparam int DIFF_W = (LEN_W > RP_W) ? LEN_W : RP_W;

  localparam logic [RP_W-1:0] RP_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_BASE = 2'd0,
    CMD_SET_LENGTH = 2'd1,
    CMD_READ_BASE  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEARCH_LENGTH   = 2'd0,
    REG_MAX_ERR         = 2'd1,
    REG_CONTROLS_IN_USE = 2'd2
  } cfg_reg_t;

  // Broadcast from the front end to every cell.
  typedef struct packed {
    logic              base_wr;
    logic              len_wr;
    logic              cmp;
    logic [IDX_W-1:0]  slot_sel;
    logic [POS_W-1:0]  wr_pos;
    logic [BASE_W-1:0] base;
    logic [LEN_W-1:0]  len;
    logic [RP_W-1:0]   rpos;
  } cell_cmd_t;

  typedef struct packed {
    logic [USED_W-1:0] used;
    logic [MERR_W-1:0] max_err;
  } match_cfg_t;

  // Result token handed from cell to cell.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] win;
    logic             rev;
    logic [CNT_W-1:0] cnt;
  } token_t;

endpackage

// ----- hw/rtl/crhm_ifs.sv -----
// Valid/ready channel interfaces for base beats and result beats.
interface crhm_item_if;
  logic                            valid;
  logic                            ready;
  logic [crhm_pkg::CMD_W-1:0]      cmd;
  logic [crhm_pkg::CIDX_W-1:0]     control_index;
  logic [crhm_pkg::FPOS_W-1:0]     position;
  logic [crhm_pkg::BASE_W-1:0]     base;
  logic [crhm_pkg::LENV_W-1:0]     length_value;
  logic                            last_base;

  modport source (output valid, cmd, control_index, position, base, length_value, last_base,
                  input ready);
  modport sink (input valid, cmd, control_index, position, base, length_value, last_base,
                output ready);
endinterface

interface crhm_result_if;
  logic                        valid;
  logic                        ready;
  logic                        is_control_match;
  logic [crhm_pkg::CIDX_W-1:0] matched_control;
  logic                        matched_reverse;
  logic [crhm_pkg::CNT_W-1:0]  mismatch_count;
  logic [crhm_pkg::NUM_W-1:0]  read_number;

  modport source (output valid, is_control_match, matched_control, matched_reverse,
                  mismatch_count, read_number, input ready);
  modport sink (input valid, is_control_match, matched_control, matched_reverse,
                mismatch_count, read_number, output ready);
endinterface

// ----- hw/rtl/crhm_cell.sv -----
// One control slot: base store, length, mismatch counters and a token stage.
module crhm_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [crhm_pkg::IDX_W-1:0]     slot,
  input  crhm_pkg::cell_cmd_t            cmd,
  input  crhm_pkg::match_cfg_t           mcfg,
  input  crhm_pkg::token_t               tok_in,
  output crhm_pkg::token_t               tok_out
);

  logic [crhm_pkg::BASE_W-1:0] bases [crhm_pkg::CONTROL_LEN];
  logic [crhm_pkg::LEN_W-1:0]  len;
  logic                        s1_valid;
  logic                        in_range;
  logic [crhm_pkg::BASE_W-1:0] base_q;
  logic [crhm_pkg::BASE_W-1:0] fwd_base;
  logic [crhm_pkg::BASE_W-1:0] rev_base;
  logic [crhm_pkg::CNT_W-1:0]  fwd_cnt;
  logic [crhm_pkg::CNT_W-1:0]  rev_cnt;
  logic [crhm_pkg::DIFF_W-1:0] rev_addr;
  logic                        fwd_miss;
  logic                        rev_miss;
  logic                        own_hit;
  logic                        own_rev;
  logic                        selected;

  // Mirror position of the reverse complement; only used when in range.
  assign rev_addr = crhm_pkg::DIFF_W'(len) - crhm_pkg::DIFF_W'(1)
                    - crhm_pkg::DIFF_W'(cmd.rpos);

  // Base store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.base_wr && cmd.slot_sel == slot) begin
      bases[cmd.wr_pos] <= cmd.base;
    end
    if (cmd.cmp) begin
      fwd_base <= bases[crhm_pkg::POS_W'(cmd.rpos)];
      rev_base <= bases[crhm_pkg::POS_W'(rev_addr)];
      base_q   <= cmd.base;
      in_range <= crhm_pkg::DIFF_W'(cmd.rpos) < crhm_pkg::DIFF_W'(len);
    end
  end

  assign fwd_miss = !in_range || (fwd_base != base_q);
  assign rev_miss = !in_range || (crhm_pkg::BASE_W'(2'd3 - rev_base) != base_q);

  assign own_hit  = (fwd_cnt <= mcfg.max_err) || (rev_cnt <= mcfg.max_err);
  assign own_rev  = !(fwd_cnt < rev_cnt);
  assign selected = own_hit && (crhm_pkg::USED_W'(slot) < mcfg.used);

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      s1_valid <= 1'b0;
      fwd_cnt  <= '0;
      rev_cnt  <= '0;
      tok_out  <= '0;
    end else begin
      if (cmd.len_wr && cmd.slot_sel == slot) begin
        len <= cmd.len;
      end
      s1_valid <= cmd.cmp;
      // The passing token samples the final counts, so they clear behind it.
      if (tok_in.valid) begin
        fwd_cnt <= '0;
        rev_cnt <= '0;
      end else if (s1_valid) begin
        fwd_cnt <= fwd_cnt + crhm_pkg::CNT_W'(fwd_miss);
        rev_cnt <= rev_cnt + crhm_pkg::CNT_W'(rev_miss);
      end
      tok_out.valid <= tok_in.valid;
      if (selected) begin
        tok_out.hit <= 1'b1;
        tok_out.win <= slot;
        tok_out.rev <= own_rev;
        tok_out.cnt <= own_rev ? rev_cnt : fwd_cnt;
      end else begin
        tok_out.hit <= tok_in.hit;
        tok_out.win <= tok_in.win;
        tok_out.rev <= tok_in.rev;
        tok_out.cnt <= tok_in.cnt;
      end
    end
  end

endmodule

// ----- hw/rtl/control_read_hamming_matcher.sv -----
// Top level of the control read matcher: front end, cell chain and result stage.
// Bases of a read are taken one beat per cycle while the input is ready; each is compared in every cell in parallel.
// After the last base of a read is taken, its result token passes launch_pre, launch and then
// the chain of cells one cell per cycle, and the result becomes valid in the output register.
// From the last base until its result enters the output register the input is not ready.
// Reset is synchronous: lengths, counters, read position, read number and settings return
// to their defaults; the base store keeps its contents and must be written before use.
module control_read_hamming_matcher (
  input  logic                            clk,
  input  logic                            rst,
  crhm_item_if.sink                       item,
  crhm_result_if.source                   result,
  input  logic                            cfg_write,
  input  logic [crhm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crhm_pkg::CFG_W-1:0]      cfg_data
);

  // Settings written through the configuration port.
  logic [crhm_pkg::SLEN_W-1:0] search_length;
  logic [crhm_pkg::MERR_W-1:0] max_err;
  logic [crhm_pkg::CUSE_W-1:0] controls_in_use;

  // Read tracking and handshake control.
  logic [crhm_pkg::RP_W-1:0]   read_position;
  logic [crhm_pkg::NUM_W-1:0]  read_counter;
  logic [crhm_pkg::NUM_W-1:0]  result_num;
  logic                        run;
  logic                        busy;
  logic                        launch_pre;
  logic                        launch;

  // Result staging: a holding register behind the output register.
  logic                        pending_valid;
  crhm_pkg::token_t            pending;
  logic                        res_valid;
  crhm_pkg::token_t            res;
  logic [crhm_pkg::NUM_W-1:0]  res_num;

  logic                        accept;
  logic                        is_read;
  logic                        acc_last;
  logic                        out_free;
  crhm_pkg::cell_cmd_t         cmd;
  crhm_pkg::match_cfg_t        mcfg;
  crhm_pkg::token_t            chain [crhm_pkg::NUM_CONTROLS + 1];
  crhm_pkg::token_t            tail;

  // The input is held off during reset and while a result token is in flight.
  assign item.ready = run && !busy;
  assign accept     = item.valid && item.ready;
  assign is_read    = accept && (item.cmd == crhm_pkg::CMD_READ_BASE);
  assign acc_last   = is_read && item.last_base;

  // Decode the beat into the command broadcast to every cell. Out-of-range slots and
  // positions are dropped here, and lengths are saturated to the store depth.
  always_comb begin
    cmd.base_wr  = accept && (item.cmd == crhm_pkg::CMD_WRITE_BASE)
                   && (int'(item.control_index) < crhm_pkg::NUM_CONTROLS)
                   && (int'(item.position) < crhm_pkg::CONTROL_LEN);
    cmd.len_wr   = accept && (item.cmd == crhm_pkg::CMD_SET_LENGTH)
                   && (int'(item.control_index) < crhm_pkg::NUM_CONTROLS);
    cmd.cmp      = is_read && (read_position < search_length);
    cmd.slot_sel = crhm_pkg::IDX_W'(item.control_index);
    cmd.wr_pos   = crhm_pkg::POS_W'(item.position);
    cmd.base     = item.base;
    cmd.len      = (int'(item.length_value) > crhm_pkg::CONTROL_LEN)
                   ? crhm_pkg::LEN_W'(crhm_pkg::CONTROL_LEN)
                   : crhm_pkg::LEN_W'(item.length_value);
    cmd.rpos     = read_position;
  end

  // Number of slots taking part, saturated to the number of cells.
  always_comb begin
    mcfg.used    = (int'(controls_in_use) > crhm_pkg::NUM_CONTROLS)
                   ? crhm_pkg::USED_W'(crhm_pkg::NUM_CONTROLS)
                   : crhm_pkg::USED_W'(controls_in_use);
    mcfg.max_err = max_err;
  end

  // The token starts empty; each cell in use that matches overwrites it, so the
  // highest matching slot is what leaves the tail of the chain.
  assign chain[0] = '{valid: launch, hit: 1'b0, win: '0, rev: 1'b0, cnt: '0};

  for (genvar i = 0; i < crhm_pkg::NUM_CONTROLS; i++) begin : g_cell
    crhm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .slot    (crhm_pkg::IDX_W'(i)),
      .cmd     (cmd),
      .mcfg    (mcfg),
      .tok_in  (chain[i]),
      .tok_out (chain[i + 1])
    );
  end

  assign tail     = chain[crhm_pkg::NUM_CONTROLS];
  assign out_free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_length   <= crhm_pkg::SLEN_W'(64);
      max_err         <= crhm_pkg::MERR_W'(3);
      controls_in_use <= crhm_pkg::CUSE_W'(16);
      read_position   <= '0;
      read_counter    <= '0;
      run             <= 1'b0;
      busy            <= 1'b0;
      launch_pre      <= 1'b0;
      launch          <= 1'b0;
      pending_valid   <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      run <= 1'b1;

      if (cfg_write) begin
        unique case (cfg_index)
          crhm_pkg::REG_SEARCH_LENGTH:   search_length   <= cfg_data;
          crhm_pkg::REG_MAX_ERR:         max_err         <= cfg_data;
          crhm_pkg::REG_CONTROLS_IN_USE: controls_in_use <= cfg_data[crhm_pkg::CUSE_W-1:0];
          default: ;
        endcase
      end

      if (is_read) begin
        if (item.last_base) begin
          read_position <= '0;
        end else if (read_position != crhm_pkg::RP_MAX) begin
          read_position <= read_position + crhm_pkg::RP_W'(1);
        end
      end

      // The counters take the last base once its store read is registered, so the token
      // passes launch_pre and launch before it enters the chain.
      launch_pre <= acc_last;
      launch     <= launch_pre;

      if (acc_last) begin
        busy         <= 1'b1;
        result_num   <= read_counter;
        read_counter <= read_counter + crhm_pkg::NUM_W'(1);
      end

      if (out_free) begin
        if (pending_valid) begin
          res           <= pending;
          res_num       <= result_num;
          res_valid     <= 1'b1;
          pending_valid <= 1'b0;
          busy          <= 1'b0;
        end else if (tail.valid) begin
          res       <= tail;
          res_num   <= result_num;
          res_valid <= 1'b1;
          busy      <= 1'b0;
        end else begin
          res_valid <= 1'b0;
        end
      end else if (tail.valid) begin
        pending       <= tail;
        pending_valid <= 1'b1;
      end
    end
  end

  assign result.valid            = res_valid;
  assign result.is_control_match = res.hit;
  assign result.matched_control  = crhm_pkg::CIDX_W'(res.win);
  assign result.matched_reverse  = res.rev;
  assign result.mismatch_count   = res.cnt;
  assign result.read_number      = res_num;

`ifndef NO_ASSERTIONS
  // Taking the last base of a read closes the input until its result is staged.
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    acc_last |=> (busy && !item.ready))
    else $error("input still open after the last base of a read");

  // A token only leaves the chain while its read is outstanding.
  a_tail_busy: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> busy)
    else $error("result token left the chain with no read outstanding");

  // The holding register is only used while the output register is full.
  a_pending_behind_out: assert property (@(posedge clk) disable iff (rst)
    pending_valid |-> res_valid)
    else $error("held result with an empty output register");

  // The read number advances by one for each read.
  a_read_count: assert property (@(posedge clk) disable iff (rst)
    acc_last |=> (read_counter == $past(read_counter) + crhm_pkg::NUM_W'(1)))
    else $error("read number did not advance by one");
`endif

endmodule
